FILE: design/sacmc_pkg.sv
// Shared types, constants and helpers of the set-associative cache miss classifier.
`default_nettype none

package sacmc_pkg;

  localparam int ADDR_W   = 31;
  localparam int LEN_W    = 7;
  localparam int MAX_SETS = 1024;
  localparam int MAX_WAYS = 16;
  localparam int SET_W    = $clog2(MAX_SETS);
  localparam int WAY_W    = $clog2(MAX_WAYS);
  localparam int MIN_OFS  = 3;
  localparam int MAX_OFS  = 6;
  localparam int BLK_W    = ADDR_W - MIN_OFS;
  localparam int TAG_W    = BLK_W;
  localparam int MAX_LEN  = 64;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  // configuration register indexes
  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_SET_BITS    = 2'd1;
  localparam logic [1:0] REG_WAY_BITS    = 2'd2;
  localparam logic [1:0] REG_POLICY      = 2'd3;

  localparam logic POLICY_RR     = 1'b0;
  localparam logic POLICY_RANDOM = 1'b1;

  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_COLD     = 2'd1,
    OUT_CONFLICT = 2'd2
  } outcome_t;

  typedef logic [TAG_W-1:0] tag_t;

  // one memory row holds a whole set
  typedef struct packed {
    logic [WAY_W-1:0]                rr_ptr;
    logic [MAX_WAYS-1:0]             valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  tags;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    outcome_t         outcome;
    logic [WAY_W-1:0] way;
    logic             write;
    logic             lfsr_step;
  } lookup_t;

  // Fibonacci LFSR, taps 0/2/3/5 fed back into bit 15
  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[15:1]};
  endfunction

endpackage

`default_nettype wire

FILE: design/set_assoc_cache_miss_classifier.sv
// Top level of the set-associative cache miss classifier.
`default_nettype none

// Splits each memory access request (byte address, byte length) into the
// cache blocks it covers, lowest address first, and classifies each block as
// hit, compulsory miss (lowest invalid way filled) or conflict miss (victim by
// per-set round-robin pointer, or by a 16-bit LFSR in random mode). One result
// per block leaves on the master stream, tlast on the final block of a request.
// All cache state lives in one synchronous RAM with one row per set (tags,
// valid bits and the round-robin pointer of all ways), so every block is a
// read-modify-write of one row: a read step, then a compare and write-back
// step that waits while the result stream stalls. A request covers 1 to 9
// blocks; the next request is accepted only after the last block of this
// one is compared. A zero-length request is accepted and gives no result.
// After reset a clearing pass writes all 1024 rows, one per cycle, and no
// request is accepted until that pass ends; configuration writes are taken
// at any time but should only be issued while no request is in flight.
module set_assoc_cache_miss_classifier (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [30:0] address, [37:31] length, [39:38] zero
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,   // [1:0] outcome, [11:2] set_number, [15:12] way_number
  output logic             m_tlast,   // last block of the request
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);
  import sacmc_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP
  } state_t;

  state_t state;

  // configuration registers
  logic [2:0] offset_bits;
  logic [3:0] set_bits;
  logic [2:0] way_bits;
  logic       policy;

  // effective (clamped) geometry
  logic [2:0] ob;
  logic [3:0] ib;
  logic [2:0] wb;

  logic [SET_W-1:0] clr_cnt;
  logic [BLK_W-1:0] blk;
  logic [3:0]       remain;     // blocks left after the current one
  logic [SET_W-1:0] cur_set;
  tag_t             cur_tag;
  logic [15:0]      lfsr;

  // request decode
  logic [ADDR_W-1:0] in_addr;
  logic [LEN_W-1:0]  in_len;
  logic [LEN_W-1:0]  len_c;
  logic [5:0]        omask;
  logic [LEN_W-1:0]  span_sum;
  logic [BLK_W-1:0]  blk_mask;
  logic [SET_W-1:0]  smask;
  logic [SET_W-1:0]  blk_set;

  // row memory
  logic             ram_rd_en;
  logic             ram_wr_en;
  logic [SET_W-1:0] ram_wr_addr;
  row_t             ram_wr_data;
  row_t             ram_rd_data;
  row_t             new_row;
  lookup_t          res;
  logic             out_free;
  logic             emit;

  always_comb begin
    if (offset_bits < 3'(MIN_OFS)) begin
      ob = 3'(MIN_OFS);
    end else if (offset_bits > 3'(MAX_OFS)) begin
      ob = 3'(MAX_OFS);
    end else begin
      ob = offset_bits;
    end
    ib = (set_bits > 4'(SET_W)) ? 4'(SET_W) : set_bits;
    wb = (way_bits > 3'(WAY_W)) ? 3'(WAY_W) : way_bits;
  end

  always_comb begin
    in_addr  = s_tdata[ADDR_W-1:0];
    in_len   = s_tdata[ADDR_W+LEN_W-1:ADDR_W];
    len_c    = (in_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : in_len;
    omask    = 6'((7'd1 << ob) - 7'd1);
    // offset + length - 1, at most 126
    span_sum = LEN_W'({1'b0, in_addr[5:0] & omask}) + len_c - LEN_W'(1);
    blk_mask = BLK_W'({ADDR_W{1'b1}} >> ob);
    smask    = SET_W'(((SET_W+1)'(1) << ib) - (SET_W+1)'(1));
    blk_set  = blk[SET_W-1:0] & smask;
  end

  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign emit      = (state == ST_CMP) && out_free;
  assign ram_rd_en = (state == ST_READ);

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = cur_set;
    ram_wr_data = new_row;
    if (state == ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_cnt;
      ram_wr_data = '0;
    end else if (emit && res.write) begin
      ram_wr_en = 1'b1;
    end
  end

  sacmc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_rows (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (blk_set),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  // read data holds while the result register is full, so the compare can wait
  sacmc_lookup u_lookup (
    .row     (ram_rd_data),
    .tag     (cur_tag),
    .wb      (wb),
    .policy  (policy),
    .lfsr    (lfsr),
    .res     (res),
    .new_row (new_row)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= 3'(MIN_OFS);
      set_bits    <= '0;
      way_bits    <= '0;
      policy      <= POLICY_RR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET_BITS: offset_bits <= cfg_data[2:0];
        REG_SET_BITS:    set_bits    <= cfg_data;
        REG_WAY_BITS:    way_bits    <= cfg_data[2:0];
        REG_POLICY:      policy      <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      lfsr     <= LFSR_SEED;
      m_tvalid <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + SET_W'(1);
          if (clr_cnt == SET_W'(MAX_SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid && in_len != '0) begin
            blk    <= BLK_W'(in_addr >> ob);
            remain <= 4'(span_sum >> ob);
            state  <= ST_READ;
          end
        end
        ST_READ: begin
          cur_set <= blk_set;
          cur_tag <= tag_t'(blk >> ib);
          state   <= ST_CMP;
        end
        ST_CMP: begin
          if (out_free) begin
            m_tdata  <= {res.way, cur_set, res.outcome};
            m_tlast  <= (remain == '0);
            if (res.lfsr_step) begin
              lfsr <= lfsr_next(lfsr);
            end
            if (remain == '0) begin
              state <= ST_IDLE;
            end else begin
              remain <= remain - 4'd1;
              blk    <= (blk + BLK_W'(1)) & blk_mask;
              state  <= ST_READ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a row is never read and written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_rd_en && ram_wr_en))
    else $error("row memory read and write in the same cycle");

  // hits leave the row untouched
  a_hit_no_write: assert property (@(posedge clk) disable iff (rst)
    (emit && res.outcome == OUT_HIT) |-> !ram_wr_en)
    else $error("row written on a hit");

  // an accepted non-empty request starts with a row read
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata[ADDR_W+LEN_W-1:ADDR_W] != '0) |=> state == ST_READ)
    else $error("accepted request did not start a lookup");

  // LFSR must never lock up at zero
  a_lfsr_live: assert property (@(posedge clk) disable iff (rst)
    lfsr != '0)
    else $error("LFSR reached zero");

  // the result register only loads from the compare step
  a_load_from_cmp: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_tvalid)) |-> $past(state) == ST_CMP)
    else $error("result loaded outside the compare step");

endmodule

`default_nettype wire

FILE: design/sacmc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sacmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data,
  input  wire logic                                     wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/sacmc_lookup.sv
// Set row compare: hit search, first free way, victim pick and updated row.
`default_nettype none

module sacmc_lookup (
  input  wire sacmc_pkg::row_t              row,
  input  wire sacmc_pkg::tag_t              tag,
  input  wire logic [2:0]                   wb,
  input  wire logic                         policy,
  input  wire logic [15:0]                  lfsr,
  output sacmc_pkg::lookup_t                res,
  output sacmc_pkg::row_t                   new_row
);
  import sacmc_pkg::*;

  logic [WAY_W-1:0]    wmask;
  logic [MAX_WAYS-1:0] hit_v;
  logic [MAX_WAYS-1:0] free_v;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    victim;
  logic [15:0]         rnd;

  always_comb begin
    wmask = WAY_W'(((WAY_W+1)'(1) << wb) - (WAY_W+1)'(1));
    for (int w = 0; w < MAX_WAYS; w++) begin
      hit_v[w]  = ((WAY_W'(w) & ~wmask) == '0) && row.valid[w] && (row.tags[w] == tag);
      free_v[w] = ((WAY_W'(w) & ~wmask) == '0) && !row.valid[w];
    end
    // lowest matching way wins
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_v[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free_v[w]) begin
        free_way = WAY_W'(w);
      end
    end
    rnd    = lfsr_next(lfsr);
    victim = (policy == POLICY_RANDOM) ? (rnd[WAY_W-1:0] & wmask) : (row.rr_ptr & wmask);

    new_row       = row;
    res.lfsr_step = 1'b0;
    if (|hit_v) begin
      res.outcome = OUT_HIT;
      res.way     = hit_way;
      res.write   = 1'b0;
    end else if (|free_v) begin
      res.outcome = OUT_COLD;
      res.way     = free_way;
      res.write   = 1'b1;
    end else begin
      res.outcome = OUT_CONFLICT;
      res.way     = victim;
      res.write   = 1'b1;
      if (policy == POLICY_RANDOM) begin
        res.lfsr_step = 1'b1;
      end else begin
        new_row.rr_ptr = (victim + WAY_W'(1)) & wmask;
      end
    end
    if (res.write) begin
      new_row.tags[res.way]  = tag;
      new_row.valid[res.way] = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb_set_assoc_cache_miss_classifier.sv
// Self-checking testbench for the set-associative cache miss classifier.
`timescale 1ns / 1ps

module tb_set_assoc_cache_miss_classifier;
  import sacmc_pkg::*;

  // Cycles with no handshake before the run is declared hung. Covers the
  // tag clear after reset plus the long result hold-off.
  localparam int QUIET_LIMIT = 5000;
  // Settle time after the last result before a register write or the end,
  // well above the worst request time of the block.
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_REPORTS = 40;

  // one access request: address in the low bits, byte length above it
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
  } access_t;

  // one per-block classification result
  typedef struct packed {
    outcome_t         outcome;
    logic [SET_W-1:0] set_no;
    logic [WAY_W-1:0] way_no;
    logic             last;
  } block_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // [30:0] address, [37:31] length, [39:38] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;       // [1:0] outcome, [11:2] set_number, [15:12] way_number
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;

  set_assoc_cache_miss_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Cache shadow: tags, valid bits, round-robin pointers, LFSR and the raw
  // register values as written (clamping is applied at lookup time).
  // ---------------------------------------------------------------------------
  logic [TAG_W-1:0] shadow_tags [MAX_SETS][MAX_WAYS];
  bit               shadow_valid[MAX_SETS][MAX_WAYS];
  logic [WAY_W-1:0] shadow_rr   [MAX_SETS];
  logic [15:0]      shadow_lfsr;
  int unsigned      ofs_reg, idx_reg, ways_reg, policy_reg;

  access_t       pending_accesses[$];   // requests not yet offered
  block_result_t expected_blocks[$];    // predicted results in arrival order
  int unsigned   accesses_queued, accesses_taken;
  int unsigned   blocks_seen;
  int unsigned   errors;
  bit            steady;                // no idling on either side

  // Classify every block an accepted request touches and queue the results.
  task automatic classify_access(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len_in);
    int unsigned   ob, ib, wb, nways, len, off, blk0, blk, blk_mask, set_no, tag, spans, way;
    bit            placed;
    outcome_t      kind;
    block_result_t r;
    ob = (ofs_reg < MIN_OFS) ? MIN_OFS : (ofs_reg > MAX_OFS) ? MAX_OFS : ofs_reg;
    ib = (idx_reg > SET_W) ? SET_W : idx_reg;
    wb = (ways_reg > WAY_W) ? WAY_W : ways_reg;
    nways = 1 << wb;
    len = 32'(len_in);
    if (len == 0) return;                // zero length: nothing happens
    if (len > MAX_LEN) len = MAX_LEN;
    off = 32'(addr) & ((1 << ob) - 1);
    blk0 = 32'(addr) >> ob;
    blk_mask = 32'h7FFF_FFFF >> ob;      // block numbers wrap at the top of memory
    spans = ((off + len - 1) >> ob) + 1;
    for (int unsigned k = 0; k < spans; k++) begin
      blk = (blk0 + k) & blk_mask;
      set_no = blk & ((1 << ib) - 1);
      tag = blk >> ib;
      placed = 0;
      way = 0;
      kind = OUT_CONFLICT;
      for (int unsigned w = 0; w < nways && !placed; w++) begin
        if (shadow_valid[set_no][w] && shadow_tags[set_no][w] == tag[TAG_W-1:0]) begin
          kind = OUT_HIT;
          way = w;
          placed = 1;
        end
      end
      if (!placed) begin
        // lowest invalid way first
        for (int unsigned w = 0; w < nways && !placed; w++) begin
          if (!shadow_valid[set_no][w]) begin
            kind = OUT_COLD;
            way = w;
            placed = 1;
          end
        end
        if (!placed) begin
          if (policy_reg == POLICY_RR) begin
            // stale pointer after a way count change is masked down
            way = 32'(shadow_rr[set_no]) & (nways - 1);
            shadow_rr[set_no] = WAY_W'((way + 1) & (nways - 1));
          end else begin
            shadow_lfsr = {shadow_lfsr[0] ^ shadow_lfsr[2] ^ shadow_lfsr[3] ^ shadow_lfsr[5],
                           shadow_lfsr[15:1]};
            way = 32'(shadow_lfsr) & (nways - 1);
          end
        end
        shadow_tags[set_no][way] = tag[TAG_W-1:0];
        shadow_valid[set_no][way] = 1'b1;
      end
      r.outcome = kind;
      r.set_no = set_no[SET_W-1:0];
      r.way_no = way[WAY_W-1:0];
      r.last = (k + 1 == spans);
      expected_blocks.push_back(r);
    end
  endtask

  task automatic report_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: offers queued requests, idles at random unless steady.
  // Prediction happens at the edge where a request is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    access_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        classify_access(s_tdata[30:0], s_tdata[37:31]);
        accesses_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_accesses.size() != 0 && (steady || $urandom_range(0, 99) >= 33)) begin
          nxt = pending_accesses.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {2'b00, nxt};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each result against the oldest prediction and
  // drives tready. Once, mid-run, it holds off for a long stretch while the
  // driver keeps offering so the block backs up into its request side.
  // ---------------------------------------------------------------------------
  int unsigned hold_left;
  bit          hold_done;

  always @(posedge clk) begin
    block_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        blocks_seen++;
        if (expected_blocks.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result with none expected, expected nothing actual tdata %h tlast %b",
                     $time, m_tdata, m_tlast);
        end else begin
          want = expected_blocks.pop_front();
          report_field("outcome", 32'(want.outcome), 32'(m_tdata[1:0]));
          report_field("set_number", 32'(want.set_no), 32'(m_tdata[11:2]));
          report_field("way_number", 32'(want.way_no), 32'(m_tdata[15:12]));
          report_field("last", 32'(want.last), 32'(m_tlast));
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && blocks_seen >= 80 && pending_accesses.size() > 10) begin
        hold_done = 1;
        hold_left = HOLD_OFF_CYCLES - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Watchdog: any handshake restarts the count.
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("set_assoc_cache_miss_classifier: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------
  task automatic push_access(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
    access_t a;
    a.addr = addr;
    a.len = len;
    pending_accesses.push_back(a);
    accesses_queued++;
  endtask

  // Register write; the shadow keeps the bits the register holds.
  task automatic reg_write(input logic [1:0] index, input logic [3:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    case (index)
      REG_OFFSET_BITS: ofs_reg = 32'(data & 4'h7);
      REG_SET_BITS:    idx_reg = 32'(data);
      REG_WAY_BITS:    ways_reg = 32'(data & 4'h7);
      REG_POLICY:      policy_reg = 32'(data & 4'h1);
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [3:0] ofs, input logic [3:0] idx,
                              input logic [3:0] wbits, input logic [3:0] pol);
    reg_write(REG_OFFSET_BITS, ofs);
    reg_write(REG_SET_BITS, idx);
    reg_write(REG_WAY_BITS, wbits);
    reg_write(REG_POLICY, pol);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued request is taken and every result is back,
  // then let any zero-length request still inside the block finish.
  task automatic drain();
    while (accesses_taken != accesses_queued || expected_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random traffic: mostly a small working set of tags over a few set
  // regions so hits and conflicts are common, some fully random addresses,
  // and a few zero or over-long lengths.
  task automatic random_phase(input int n);
    logic [14:0]       highs[8];
    logic [15:0]       lows[4];
    logic [ADDR_W-1:0] a;
    logic [LEN_W-1:0]  l;
    int unsigned       pick;
    foreach (highs[i]) highs[i] = 15'($urandom);
    foreach (lows[i]) lows[i] = 16'($urandom);
    highs[0] = '1;   // keeps the top of memory (and wrap) in the mix
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75)
        a = {highs[$urandom_range(0, 7)], 16'(lows[$urandom_range(0, 3)] + $urandom_range(0, 63))};
      else
        a = ADDR_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 5) l = '0;
      else if (pick < 10) l = LEN_W'($urandom_range(MAX_LEN + 1, 127));
      else l = LEN_W'($urandom_range(1, MAX_LEN));
      push_access(a, l);
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (shadow_valid[s, w]) shadow_valid[s][w] = 1'b0;
    foreach (shadow_rr[s]) shadow_rr[s] = '0;
    shadow_lfsr = LFSR_SEED;
    ofs_reg = MIN_OFS;
    idx_reg = 0;
    ways_reg = 0;
    policy_reg = POLICY_RR;
    steady = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // 8-byte blocks, 4 sets, 2 ways, round robin: set = addr[4:3], tag = addr >> 5
    program_regs(4'd3, 4'd2, 4'd1, 4'(POLICY_RR));
    push_access(31'd0, 7'd1);             // cold fill of way 0
    push_access(31'd0, 7'd1);             // hit
    push_access(31'd32, 7'd1);            // cold fill of way 1
    push_access(31'd64, 7'd1);            // set full: round-robin victim
    push_access(31'd96, 7'd8);            // next round-robin victim
    push_access(31'd0, 7'd1);             // evicted tag comes back as a conflict
    push_access(31'd5, 7'd64);            // worst case: nine blocks
    push_access(31'd100, 7'd0);           // zero length, no result
    push_access(31'd200, 7'd127);         // over-long, clamped to 64
    push_access(31'd300, 7'd65);
    push_access(31'h7FFF_FFFF, 7'd64);    // runs off the top, wraps to block 0
    push_access(31'h7FFF_FFC0, 7'd64);
    push_access(31'h7FFF_FFFF, 7'd1);
    drain();

    // 64-byte blocks, 1024 sets, 2 ways, LFSR victims on one set
    program_regs(4'd6, 4'd10, 4'd1, 4'(POLICY_RANDOM));
    for (int t = 0; t < 5; t++) push_access(31'(t << 16), 7'd1);
    drain();

    // out-of-range values clamp to 64-byte blocks, 1024 sets, 16 ways
    program_regs(4'hF, 4'hF, 4'hF, 4'hE);
    random_phase(40);

    // below-range block size clamps to 8 bytes; direct mapped, one set
    program_regs(4'd0, 4'd0, 4'd0, 4'(POLICY_RANDOM));
    random_phase(35);

    // no idling on either side for this stretch
    steady = 1;
    program_regs(4'd4, 4'd5, 4'd2, 4'(POLICY_RR));
    random_phase(40);
    steady = 0;

    program_regs(4'd5, 4'd3, 4'd3, 4'(POLICY_RANDOM));
    random_phase(40);

    program_regs(4'd3, 4'd1, 4'd4, 4'(POLICY_RR));
    random_phase(40);

    // way count shrinks: old round-robin pointers must be masked
    program_regs(4'd6, 4'd8, 4'd1, 4'(POLICY_RR));
    random_phase(40);

    if (errors == 0) begin
      $display("set_assoc_cache_miss_classifier: match");
    end else begin
      $display("set_assoc_cache_miss_classifier: mismatch");
    end
    $finish;
  end

endmodule

FILE: set_assoc_cache_miss_classifier.f
design/sacmc_pkg.sv
design/sacmc_ram.sv
design/sacmc_lookup.sv
design/set_assoc_cache_miss_classifier.sv
tb/tb_set_assoc_cache_miss_classifier.sv
